// ===== rtl/core/hbmdc_pkg.sv =====
// ----------------------------------------------------------------------------
// hbmdc_pkg
// Shared codes, constants and control types of the H-bridge duty controller.
// ----------------------------------------------------------------------------
package hbmdc_pkg;

  // command codes (s_tuser)
  localparam logic [2:0] CMD_SET_SPEED = 3'd0;
  localparam logic [2:0] CMD_BRAKE     = 3'd1;
  localparam logic [2:0] CMD_PWM_DONE  = 3'd2;
  localparam logic [2:0] CMD_TICK      = 3'd3;
  localparam logic [2:0] CMD_ADC       = 3'd4;

  // motor modes
  localparam logic [1:0] MODE_COAST = 2'd0;
  localparam logic [1:0] MODE_DRIVE = 2'd1;
  localparam logic [1:0] MODE_BRAKE = 2'd2;

  // config register indexes
  localparam logic [1:0] REG_OFF_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_SOFT_START    = 2'd1;
  localparam logic [1:0] REG_TIMEOUT       = 2'd2;

  // config reset values
  localparam logic [6:0]  OFF_THRESHOLD_RST = 7'd6;
  localparam logic [6:0]  SOFT_START_RST    = 7'd70;
  localparam logic [15:0] TIMEOUT_RST       = 16'd700;

  localparam logic [6:0]  DUTY_MAX  = 7'd100;
  localparam logic [15:0] PWM_FLAG  = 16'h8000;
  localparam logic [15:0] MS_SAT    = 16'hFFFF;

  // current scaling: ma = trunc(trunc(adc * 6000 / 1024) * 125 / 18)
  localparam logic [12:0] VOLT_NUM    = 13'd6000;
  localparam logic [6:0]  MA_NUM      = 7'd125;
  localparam logic [15:0] MA_RECIP    = 16'd58254;  // floor(2^20 / 18)
  localparam logic [4:0]  MA_DEN      = 5'd18;

  // last count of the wait after an ADC sample write; the 4-stage scaling
  // has registered the new current when the wait ends
  localparam logic [1:0]  SCALE_LAST  = 2'd3;

  typedef struct packed {
    logic accept;  // input beat taken, commit state
    logic push;    // load the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_is_adc;  // offered beat writes the ADC sample
  } dp_status_t;

endpackage

// ===== rtl/core/hbmdc_ctrl.sv =====
// ----------------------------------------------------------------------------
// hbmdc_ctrl
// Sequencer: takes one beat, waits for the current scaling when needed and
// loads the output register once it is free.
// ----------------------------------------------------------------------------
module hbmdc_ctrl
  import hbmdc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  output logic       m_tvalid,
  input  logic       m_tready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCALE = 2'd1;
  localparam logic [1:0] ST_PUSH  = 2'd2;

  logic [1:0] state, state_next;
  logic [1:0] cnt, cnt_next;
  logic       m_tvalid_next;

  assign s_tready   = (state == ST_IDLE);
  assign cmd.accept = s_tvalid && s_tready;
  assign cmd.push   = (state == ST_PUSH) && (!m_tvalid || m_tready);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      ST_IDLE: begin
        cnt_next = '0;
        if (cmd.accept) begin
          state_next = status.in_is_adc ? ST_SCALE : ST_PUSH;
        end
      end
      ST_SCALE: begin
        cnt_next = cnt + 2'd1;
        if (cnt == SCALE_LAST) begin
          state_next = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (cmd.push) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.push) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end else begin
      m_tvalid_next = m_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  a_adc_waits: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && status.in_is_adc) |=> (state == ST_SCALE))
    else $error("ADC beat did not wait for scaling");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> (!m_tvalid || m_tready))
    else $error("output beat overwritten");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> !s_tready)
    else $error("second beat taken before result");

  a_scale_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCALE && cnt == SCALE_LAST) |=> (state == ST_PUSH))
    else $error("scaling wait overran");

endmodule

// ===== rtl/core/hbmdc_dp.sv =====
// ----------------------------------------------------------------------------
// hbmdc_dp
// Datapath: config registers, duty quantizer, PWM update bookkeeping,
// pipelined current scaling and the output register.
// ----------------------------------------------------------------------------
module hbmdc_dp
  import hbmdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic [2:0]  in_user,
  input  logic [31:0] in_data,
  input  ctrl_cmd_t   cmd,
  output dp_status_t  status,
  output logic [55:0] out_data
);

  // config
  logic [6:0]  off_threshold;
  logic [6:0]  soft_start_duty;
  logic [15:0] update_timeout_ms;

  // controller state
  logic [6:0]  previous_duty;
  logic        previous_reverse;
  logic [1:0]  mode;
  logic [7:0]  stored_speed;
  logic        update_pending;
  logic        pwm_ready;
  logic [15:0] ms_since_load;
  logic [11:0] adc_latest;

  // per-item result held until the output register loads
  logic [6:0]  res_applied;
  logic        res_load;
  logic [15:0] res_word;
  logic        res_tout;
  logic        res_sreq;

  // input fields
  logic [2:0]  in_cmd;
  logic [7:0]  in_speed;
  logic        in_force;
  logic [7:0]  in_brake;
  logic [11:0] in_adc;

  assign in_cmd   = in_user;
  assign in_speed = in_data[7:0];
  assign in_force = in_data[8];
  assign in_brake = in_data[16:9];
  assign in_adc   = in_data[28:17];

  assign status.in_is_adc = (in_cmd == CMD_ADC);

  // quantizer and next-state logic
  logic        rev;
  logic [7:0]  mag;
  logic [7:0]  raw;
  logic [6:0]  lvl;
  logic        force_q;
  logic [6:0]  qt;
  logic        q_pend;
  logic [15:0] ms_inc;
  logic        tout;
  logic        load;

  logic [6:0]  previous_duty_next;
  logic        previous_reverse_next;
  logic [1:0]  mode_next;
  logic [7:0]  stored_speed_next;
  logic        update_pending_next;
  logic        pwm_ready_next;
  logic [15:0] ms_since_load_next;
  logic [11:0] adc_latest_next;
  logic [6:0]  applied;
  logic [15:0] word;
  logic        sreq;

  always_comb begin
    rev     = in_speed[7];
    mag     = rev ? (~in_speed + 8'd1) : in_speed;  // -128 reads as 128
    raw     = (in_cmd == CMD_BRAKE) ? in_brake : mag;
    lvl     = (raw > {1'b0, DUTY_MAX}) ? DUTY_MAX : raw[6:0];
    force_q = (in_cmd == CMD_BRAKE) || (rev != previous_reverse) || in_force;

    q_pend = 1'b0;
    if (lvl > off_threshold) begin
      if ((lvl != previous_duty) || force_q) begin
        // (d & ~15) | 16
        qt = {lvl[6:5], 1'b1, 4'b0000};
        if (qt > DUTY_MAX) begin
          qt = DUTY_MAX;
        end
        if ((qt == DUTY_MAX) && (previous_duty == '0)) begin
          qt = soft_start_duty;
        end
        q_pend = 1'b1;
      end else begin
        qt = lvl;
      end
    end else begin
      qt     = '0;
      q_pend = 1'b1;
    end

    ms_inc = (ms_since_load == MS_SAT) ? ms_since_load : ms_since_load + 16'd1;
    tout   = update_pending && !pwm_ready && (ms_inc > update_timeout_ms);
    load   = (pwm_ready || tout) && update_pending;

    previous_duty_next    = previous_duty;
    previous_reverse_next = previous_reverse;
    mode_next             = mode;
    stored_speed_next     = stored_speed;
    update_pending_next   = update_pending;
    pwm_ready_next        = pwm_ready;
    ms_since_load_next    = ms_since_load;
    adc_latest_next       = adc_latest;
    applied               = '0;
    word                  = '0;
    sreq                  = 1'b0;

    case (in_cmd)
      CMD_SET_SPEED: begin
        applied               = qt;
        previous_duty_next    = qt;
        previous_reverse_next = rev;
        update_pending_next   = update_pending || q_pend;
        if (qt == '0) begin
          mode_next         = MODE_COAST;
          stored_speed_next = '0;
        end else begin
          mode_next         = MODE_DRIVE;
          stored_speed_next = rev ? (~{1'b0, qt} + 8'd1) : {1'b0, qt};
        end
      end
      CMD_BRAKE: begin
        applied             = qt;
        previous_duty_next  = qt;
        mode_next           = MODE_BRAKE;
        update_pending_next = update_pending || q_pend;
      end
      CMD_PWM_DONE: begin
        pwm_ready_next = 1'b1;
      end
      CMD_TICK: begin
        if (load) begin
          pwm_ready_next      = 1'b0;
          update_pending_next = 1'b0;
          ms_since_load_next  = '0;
          word                = {{8{stored_speed[7]}}, stored_speed} | PWM_FLAG;
        end else begin
          ms_since_load_next = ms_inc;
          sreq               = 1'b1;
        end
      end
      CMD_ADC: begin
        adc_latest_next = in_adc;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      off_threshold     <= OFF_THRESHOLD_RST;
      soft_start_duty   <= SOFT_START_RST;
      update_timeout_ms <= TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OFF_THRESHOLD: off_threshold     <= cfg_data[6:0];
        REG_SOFT_START:    soft_start_duty   <= cfg_data[6:0];
        REG_TIMEOUT:       update_timeout_ms <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_duty    <= '0;
      previous_reverse <= 1'b0;
      mode             <= MODE_COAST;
      stored_speed     <= '0;
      update_pending   <= 1'b0;
      pwm_ready        <= 1'b0;
      ms_since_load    <= '0;
      adc_latest       <= '0;
    end else if (cmd.accept) begin
      previous_duty    <= previous_duty_next;
      previous_reverse <= previous_reverse_next;
      mode             <= mode_next;
      stored_speed     <= stored_speed_next;
      update_pending   <= update_pending_next;
      pwm_ready        <= pwm_ready_next;
      ms_since_load    <= ms_since_load_next;
      adc_latest       <= adc_latest_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_applied <= applied;
      res_load    <= (in_cmd == CMD_TICK) && load;
      res_word    <= word;
      res_tout    <= (in_cmd == CMD_TICK) && tout;
      res_sreq    <= sreq;
    end
  end

  // current scaling, free running on adc_latest; magnitudes keep the
  // truncation toward zero
  logic        neg1, neg2, neg3;
  logic [13:0] volt_mag;
  logic [20:0] x2, x3;
  logic [16:0] q0;
  logic [17:0] current_ma;

  logic [11:0] adc_abs;
  logic [24:0] volt_prod;
  logic [20:0] x_prod;
  logic [36:0] recip_prod;
  logic [21:0] q0_x18;
  logic [21:0] rem;
  logic [16:0] q_fix;

  always_comb begin
    adc_abs    = adc_latest[11] ? (~adc_latest + 12'd1) : adc_latest;
    volt_prod  = {13'd0, adc_abs} * {12'd0, VOLT_NUM};
    x_prod     = {7'd0, volt_mag} * {14'd0, MA_NUM};
    recip_prod = {16'd0, x2} * {21'd0, MA_RECIP};
    q0_x18     = {1'b0, q0, 4'b0000} + {4'd0, q0, 1'b0};
    rem        = {1'b0, x3} - q0_x18;
    // reciprocal is at most one short
    q_fix      = (rem >= {17'd0, MA_DEN}) ? q0 + 17'd1 : q0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      neg1       <= 1'b0;
      neg2       <= 1'b0;
      neg3       <= 1'b0;
      volt_mag   <= '0;
      x2         <= '0;
      x3         <= '0;
      q0         <= '0;
      current_ma <= '0;
    end else begin
      neg1       <= adc_latest[11];
      volt_mag   <= volt_prod[23:10];
      neg2       <= neg1;
      x2         <= x_prod;
      neg3       <= neg2;
      x3         <= x2;
      q0         <= recip_prod[36:20];
      current_ma <= neg3 ? (~{1'b0, q_fix} + 18'd1) : {1'b0, q_fix};
    end
  end

  // output register
  logic [6:0]  out_applied;
  logic [7:0]  out_speed;
  logic        out_a;
  logic        out_b;
  logic [1:0]  out_mode;
  logic        out_load;
  logic [15:0] out_word;
  logic        out_tout;
  logic        out_sreq;
  logic [17:0] out_ma;

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_applied <= res_applied;
      out_speed   <= stored_speed;
      out_a       <= (mode == MODE_DRIVE) && !stored_speed[7] && (stored_speed != '0);
      out_b       <= (mode == MODE_DRIVE) && stored_speed[7];
      out_mode    <= mode;
      out_load    <= res_load;
      out_word    <= res_word;
      out_tout    <= res_tout;
      out_sreq    <= res_sreq;
      out_ma      <= current_ma;
    end
  end

  assign out_data = {out_ma, out_sreq, out_tout, out_word, out_load, out_mode,
                     out_b, out_a, out_speed, out_applied};

  a_load_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && in_cmd == CMD_TICK && load)
      |=> (!update_pending && !pwm_ready && ms_since_load == '0))
    else $error("PWM load left update state set");

  a_drive_has_speed: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_DRIVE) |-> (stored_speed != '0))
    else $error("driving with zero speed");

  a_timeout_needs_pending: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && in_cmd == CMD_TICK && tout) |-> load)
    else $error("timeout without load");

endmodule

// ===== rtl/core/hbridge_motor_duty_controller.sv =====
// ----------------------------------------------------------------------------
// hbridge_motor_duty_controller
// H-bridge duty controller for one motor: speed/brake commands, PWM update
// pacing on millisecond ticks, current-sense scaling to milliamps.
//
//   channel   dir  beat                         notes
//   s_*       in   one command                  cmd in tuser
//   m_*       out  one status/result per beat   one beat per input beat
//   cfg_*     in   register write               0 off thr, 1 soft start, 2 timeout
//
// A beat is taken in ST_IDLE and its result is loaded into the output
// register in ST_PUSH once that is free. An ADC sample beat first waits
// in ST_SCALE for the 4-stage current scaling pipeline behind adc_latest.
// One beat is processed at a time; a new beat is taken while the last result
// still waits on m_tready and its result loads once that one has left.
// Reset is synchronous; no clearing pass.
// ----------------------------------------------------------------------------
module hbridge_motor_duty_controller
  import hbmdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  // speed[7:0], force_req[8], brake_level[16:9], adc_sample[28:17], zero[31:29]
  input  logic [31:0] s_tdata,
  // cmd[2:0]
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // applied_duty[6:0], signed_speed[14:7], drive_a[15], drive_b[16],
  // motor_mode[18:17], pwm_load[19], pwm_word[35:20], pwm_timed_out[36],
  // sample_request[37], current_ma[55:38]
  output logic [55:0] m_tdata
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  hbmdc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  hbmdc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_user   (s_tuser),
    .in_data   (s_tdata),
    .cmd       (cmd),
    .status    (status),
    .out_data  (m_tdata)
  );

endmodule

// ===== dv/tb_hbridge_motor_duty_controller.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hbridge_motor_duty_controller
// Self-checking bench for the H-bridge duty controller. A directed table is
// run first: reset status, level extremes, soft start, brake, reserved
// codes. Random command streams follow under several register settings and
// idle/stall mixes. Short tick runs check the largest timeout settings.
// Each status beat is checked per field against its typed row or a predictor.
// ----------------------------------------------------------------------------
module tb_hbridge_motor_duty_controller;
  import hbmdc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned TAIL_CYCLES = 12;
  localparam int unsigned DIR_ROWS    = 25;
  localparam int unsigned LONG_TICKS  = 20;
  localparam int unsigned MAX_PRINTS  = 50;

  localparam logic [1:0] REG_SPARE  = 2'd3;
  localparam logic [2:0] CMD_RSVD_A = 3'd5;
  localparam logic [2:0] CMD_RSVD_B = 3'd6;
  localparam logic [2:0] CMD_RSVD_C = 3'd7;

  // milliamp scaling
  localparam int ADC_MV_NUM = 6000;
  localparam int ADC_MV_DEN = 1024;
  localparam int MA_NUM_TB  = 1000;
  localparam int MA_DEN_TB  = 144;

  typedef struct packed {
    logic signed [17:0] current_ma;
    logic               sample_request;
    logic               pwm_timed_out;
    logic [15:0]        pwm_word;
    logic               pwm_load;
    logic [1:0]         motor_mode;
    logic               drive_b;
    logic               drive_a;
    logic signed [7:0]  signed_speed;
    logic [6:0]         applied_duty;
  } duty_status_t;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [7:0]  speed;
    logic               force_req;
    logic [7:0]         brake_level;
    logic signed [11:0] adc_sample;
    logic               typed;
    duty_status_t       want;
  } stim_row_t;

  localparam duty_status_t NO_STATUS = '0;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic [2:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;

  hbridge_motor_duty_controller dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // predictor copy of registers and state
  logic [6:0]         off_thr;
  logic [6:0]         soft_duty;
  logic [15:0]        tmo_ms;
  logic [6:0]         prev_duty;
  logic               prev_rev;
  logic [1:0]         motor_mode;
  logic signed [7:0]  speed_q;
  logic               upd_pending;
  logic               pwm_ready;
  int unsigned        ms_count;
  logic signed [11:0] adc_q;

  duty_status_t       status_due[$];
  stim_row_t          dir_rows [DIR_ROWS];
  int unsigned        err_count;
  int unsigned        rx_count;
  int unsigned        cycle_count;
  int unsigned        idle_pct;
  int unsigned        stall_pct;
  logic signed [7:0]  last_spd;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void model_reset();
    off_thr     = OFF_THRESHOLD_RST;
    soft_duty   = SOFT_START_RST;
    tmo_ms      = TIMEOUT_RST;
    prev_duty   = '0;
    prev_rev    = 1'b0;
    motor_mode  = MODE_COAST;
    speed_q     = '0;
    upd_pending = 1'b0;
    pwm_ready   = 1'b0;
    ms_count    = 0;
    adc_q       = '0;
  endfunction

  function automatic logic [6:0] quantize_duty(input int unsigned lvl_in, input logic frc);
    int unsigned lvl;
    lvl = (lvl_in > DUTY_MAX) ? DUTY_MAX : lvl_in;
    if (lvl > off_thr) begin
      if (lvl != prev_duty || frc) begin
        lvl = (lvl & ~32'd15) | 32'd16;
        if (lvl > DUTY_MAX) lvl = DUTY_MAX;
        // jump from zero straight to full uses the soft-start level
        if (lvl == DUTY_MAX && prev_duty == 0) lvl = soft_duty;
        upd_pending = 1'b1;
      end
    end else begin
      upd_pending = 1'b1;
      lvl = 0;
    end
    prev_duty = lvl[6:0];
    return prev_duty;
  endfunction

  function automatic duty_status_t predict_status(input logic [2:0] cmd,
      input logic signed [7:0] spd, input logic frc, input logic [7:0] brk,
      input logic signed [11:0] adc);
    duty_status_t r;
    int           spd_i;
    int           mag;
    int           duty;
    int           adc_i;
    int           volt;
    logic         rev;
    logic         frc_eff;
    r = '0;
    case (cmd)
      CMD_SET_SPEED: begin
        spd_i = spd;
        rev = (spd_i < 0);
        mag = rev ? -spd_i : spd_i;
        // a direction change always requantizes
        frc_eff = (rev == prev_rev) ? frc : 1'b1;
        motor_mode = MODE_DRIVE;
        r.applied_duty = quantize_duty(mag, frc_eff);
        if (r.applied_duty == 0) motor_mode = MODE_COAST;
        prev_rev = rev;
        duty = r.applied_duty;
        speed_q = rev ? -duty : duty;
      end
      CMD_BRAKE: begin
        motor_mode = MODE_BRAKE;
        r.applied_duty = quantize_duty(brk, 1'b1);
      end
      CMD_PWM_DONE: pwm_ready = 1'b1;
      CMD_TICK: begin
        if (ms_count < MS_SAT) ms_count++;
        if (upd_pending && !pwm_ready && ms_count > tmo_ms) begin
          pwm_ready = 1'b1;
          r.pwm_timed_out = 1'b1;
        end
        if (pwm_ready && upd_pending) begin
          pwm_ready = 1'b0;
          r.pwm_load = 1'b1;
          r.pwm_word = {{8{speed_q[7]}}, speed_q} | PWM_FLAG;
          upd_pending = 1'b0;
          ms_count = 0;
        end else begin
          r.sample_request = 1'b1;
        end
      end
      CMD_ADC: adc_q = adc;
      default: ;
    endcase
    r.signed_speed = speed_q;
    r.motor_mode = motor_mode;
    if (motor_mode == MODE_DRIVE) begin
      r.drive_a = (speed_q > 0);
      r.drive_b = (speed_q < 0);
    end
    adc_i = adc_q;
    volt = adc_i * ADC_MV_NUM / ADC_MV_DEN;
    r.current_ma = volt * MA_NUM_TB / MA_DEN_TB;
    return r;
  endfunction

  task automatic report_err(input string msg);
    err_count++;
    if (err_count <= MAX_PRINTS) $display("[%0t] %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [17:0] got,
                             input logic [17:0] want);
    if (got !== want)
      report_err($sformatf("status %0d %s: got 0x%0h want 0x%0h", rx_count, name, got, want));
  endtask

  task automatic check_status(input duty_status_t got, input duty_status_t want);
    check_field("applied_duty",   got.applied_duty,   want.applied_duty);
    check_field("signed_speed",   got.signed_speed,   want.signed_speed);
    check_field("drive_a",        got.drive_a,        want.drive_a);
    check_field("drive_b",        got.drive_b,        want.drive_b);
    check_field("motor_mode",     got.motor_mode,     want.motor_mode);
    check_field("pwm_load",       got.pwm_load,       want.pwm_load);
    check_field("pwm_word",       got.pwm_word,       want.pwm_word);
    check_field("pwm_timed_out",  got.pwm_timed_out,  want.pwm_timed_out);
    check_field("sample_request", got.sample_request, want.sample_request);
    check_field("current_ma",     got.current_ma,     want.current_ma);
  endtask

  // result side: check accepted beats, stall at random
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (status_due.size() == 0)
        report_err($sformatf("status %0d arrived with nothing expected", rx_count));
      else
        check_status(duty_status_t'(m_tdata), status_due.pop_front());
      rx_count++;
    end
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  task automatic send_beat(input logic [2:0] cmd, input logic signed [7:0] spd,
      input logic frc, input logic [7:0] brk, input logic signed [11:0] adc,
      input logic typed, input duty_status_t want);
    duty_status_t pred;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {3'b000, adc, brk, frc, spd};
    do @(posedge clk); while (!s_tready);
    pred = predict_status(cmd, spd, frc, brk, adc);
    status_due.push_back(typed ? want : pred);
  endtask

  task automatic rand_item(input logic [2:0] cmd);
    logic signed [7:0] spd;
    logic [7:0]        brk;
    int                mag;
    int unsigned       sel;
    sel = $urandom_range(99);
    if (sel < 35) begin
      spd = 8'($urandom);
    end else if (sel < 60) begin
      // repeat the last level, sometimes flipped, to hit the unchanged path
      spd = ($urandom_range(4) == 0) ? -last_spd : last_spd;
    end else begin
      mag = $urandom_range(110);
      spd = $urandom_range(1) ? -mag : mag;
    end
    if (cmd == CMD_SET_SPEED) last_spd = spd;
    brk = ($urandom_range(2) == 0) ? 8'($urandom_range(20)) : 8'($urandom_range(255));
    send_beat(cmd, spd, 1'($urandom_range(1)), brk, 12'($urandom), 1'b0, NO_STATUS);
  endtask

  task automatic run_random(input int unsigned n);
    int unsigned sent;
    int unsigned pick;
    int unsigned burst;
    logic [2:0]  cmd;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(99);
      if (pick < 26) cmd = CMD_SET_SPEED;
      else if (pick < 36) cmd = CMD_BRAKE;
      else if (pick < 45) cmd = CMD_PWM_DONE;
      else if (pick < 84) cmd = CMD_TICK;
      else if (pick < 95) cmd = CMD_ADC;
      else cmd = 3'($urandom_range(CMD_RSVD_A, CMD_RSVD_C));
      // tick bursts long enough to run out the timeout
      if (cmd == CMD_TICK && $urandom_range(9) == 0 && tmo_ms < 64) begin
        burst = tmo_ms + 2;
        repeat (burst) rand_item(CMD_TICK);
        sent += burst;
      end else begin
        rand_item(cmd);
        sent++;
      end
    end
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [6:0] off, input logic [6:0] soft_lvl,
                            input logic [15:0] tmo);
    cfg_we    <= 1'b1;
    cfg_index <= REG_OFF_THRESHOLD;
    cfg_data  <= 16'(off);
    @(posedge clk);
    cfg_index <= REG_SOFT_START;
    cfg_data  <= 16'(soft_lvl);
    @(posedge clk);
    cfg_index <= REG_TIMEOUT;
    cfg_data  <= tmo;
    @(posedge clk);
    // spare index must be ignored
    cfg_index <= REG_SPARE;
    cfg_data  <= 16'($urandom);
    @(posedge clk);
    cfg_we    <= 1'b0;
    off_thr   = off;
    soft_duty = soft_lvl;
    tmo_ms    = tmo;
  endtask

  task automatic run_phase(input logic [6:0] off, input logic [6:0] soft_lvl,
      input logic [15:0] tmo, input int unsigned idle, input int unsigned stall,
      input int unsigned n);
    settle();
    set_config(off, soft_lvl, tmo);
    idle_pct  = idle;
    stall_pct = stall;
    run_random(n);
  endtask

  initial begin
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= REG_OFF_THRESHOLD;
    cfg_data  <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= CMD_SET_SPEED;
    m_tready  <= 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    err_count = 0;
    rx_count  = 0;
    last_spd  = '0;
    model_reset();

    //            cmd            speed frc brake adc    typed  expected status
    dir_rows = '{
      '{CMD_TICK,      0,    0, 0,   0,     1, '{0, 1, 0, 0, 0, MODE_COAST, 0, 0, 0, 0}},
      '{CMD_PWM_DONE,  0,    0, 0,   0,     1, NO_STATUS},
      '{CMD_TICK,      0,    0, 0,   0,     1, '{0, 1, 0, 0, 0, MODE_COAST, 0, 0, 0, 0}},
      '{CMD_ADC,       0,    0, 0,   -2048, 1, '{-83333, 0, 0, 0, 0, MODE_COAST, 0, 0, 0, 0}},
      '{CMD_ADC,       0,    0, 0,   2047,  0, NO_STATUS},
      '{CMD_ADC,       0,    0, 0,   0,     1, NO_STATUS},
      '{CMD_SET_SPEED, 127,  0, 0,   0,     1, '{0, 0, 0, 0, 0, MODE_DRIVE, 0, 1, 70, 70}},
      '{CMD_TICK,      0,    0, 0,   0,     0, NO_STATUS},
      '{CMD_SET_SPEED, -128, 0, 0,   0,     1, '{0, 0, 0, 0, 0, MODE_DRIVE, 1, 0, -100, 100}},
      '{CMD_SET_SPEED, -100, 0, 0,   0,     0, NO_STATUS},
      '{CMD_SET_SPEED, -100, 1, 0,   0,     0, NO_STATUS},
      '{CMD_SET_SPEED, 0,    0, 0,   0,     1, NO_STATUS},
      '{CMD_SET_SPEED, 6,    0, 0,   0,     0, NO_STATUS},
      '{CMD_SET_SPEED, 7,    0, 0,   0,     0, NO_STATUS},
      '{CMD_SET_SPEED, 16,   0, 0,   0,     0, NO_STATUS},
      '{CMD_SET_SPEED, 47,   0, 0,   0,     0, NO_STATUS},
      '{CMD_SET_SPEED, -47,  0, 0,   0,     0, NO_STATUS},
      '{CMD_BRAKE,     0,    0, 255, 0,     0, NO_STATUS},
      '{CMD_BRAKE,     0,    0, 0,   0,     0, NO_STATUS},
      '{CMD_PWM_DONE,  0,    0, 0,   0,     0, NO_STATUS},
      '{CMD_TICK,      0,    0, 0,   0,     0, NO_STATUS},
      '{CMD_RSVD_A,    0,    0, 0,   0,     0, NO_STATUS},
      '{CMD_RSVD_B,    0,    0, 0,   0,     0, NO_STATUS},
      '{CMD_RSVD_C,    0,    0, 0,   0,     0, NO_STATUS},
      '{CMD_SET_SPEED, 100,  0, 0,   0,     0, NO_STATUS}
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++)
      send_beat(dir_rows[i].cmd, dir_rows[i].speed, dir_rows[i].force_req,
                dir_rows[i].brake_level, dir_rows[i].adc_sample, dir_rows[i].typed,
                dir_rows[i].want);

    run_phase(7'd6,   7'd70,  16'd20, 0,  0,  140);
    run_phase(7'd0,   7'd100, 16'd0,  82, 0,  140);
    run_phase(7'd100, 7'd45,  16'd5,  0,  82, 140);
    run_phase(7'd31,  7'd0,   16'd3,  30, 30, 140);
    run_phase(7'($urandom_range(100)), 7'($urandom_range(100)),
              16'($urandom_range(40)), 0, 0, 140);

    // maximum timeout never fires
    settle();
    set_config(7'd6, 7'd70, MS_SAT);
    idle_pct  = 0;
    stall_pct = 0;
    send_beat(CMD_SET_SPEED, 8'sd50, 1'b1, 8'd0, 12'sd0, 1'b0, NO_STATUS);
    rand_item(CMD_TICK);
    send_beat(CMD_SET_SPEED, 8'sd50, 1'b1, 8'd0, 12'sd0, 1'b0, NO_STATUS);
    repeat (LONG_TICKS) rand_item(CMD_TICK);

    // timeout one below the maximum
    settle();
    set_config(7'd6, 7'd70, MS_SAT - 16'd1);
    idle_pct  = 30;
    stall_pct = 30;
    rand_item(CMD_TICK);
    run_random(20);

    settle();
    if (status_due.size() != 0)
      report_err($sformatf("%0d status beats never arrived", status_due.size()));
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/hbmdc_pkg.sv
rtl/core/hbmdc_ctrl.sv
rtl/core/hbmdc_dp.sv
rtl/core/hbridge_motor_duty_controller.sv
dv/tb_hbridge_motor_duty_controller.sv
